// ===== hw/rtl/pars_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pars_pkg;
    localparam int unsigned PW = 24;
    localparam int unsigned DW = 25;       // center minus position
    localparam int unsigned SQW = 50;      // dx*dx + dy*dy
    localparam int unsigned LW = 25;       // floor of square root
    localparam int unsigned QW = 28;       // force quotient
    localparam int unsigned NW = 42;       // force dividend
    localparam int unsigned RAW = 5;       // APB address bits

    // snap distance from the window edge, whole pixels
    localparam int EDGE_MARGIN = 50;

    localparam logic [RAW-1:0] A_CENTER_X = 5'd0;
    localparam logic [RAW-1:0] A_CENTER_Y = 5'd4;
    localparam logic [RAW-1:0] A_WIDTH    = 5'd8;
    localparam logic [RAW-1:0] A_HEIGHT   = 5'd12;
    localparam logic [RAW-1:0] A_THRESH   = 5'd16;
    localparam logic [RAW-1:0] A_GAIN     = 5'd20;

    typedef struct packed {
        logic signed [PW-1:0] pos_x;
        logic signed [PW-1:0] pos_y;
        logic signed [PW-1:0] vel_x;
        logic signed [PW-1:0] vel_y;
        logic [15:0]          drag;
        logic [15:0]          sound_level;
    } t_in;

    typedef struct packed {
        logic signed [PW-1:0] new_pos_x;
        logic signed [PW-1:0] new_pos_y;
        logic signed [PW-1:0] new_vel_x;
        logic signed [PW-1:0] new_vel_y;
        logic                 repelled;
    } t_out;

    // classified item passed from front to back
    typedef struct packed {
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [PW-1:0] vx;
        logic signed [PW-1:0] vy;
        logic [15:0]          drag;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic                 rep;
    } t_cls;

    function automatic logic signed [PW-1:0] sat24(input logic signed [PW+2:0] v);
        if (v > 27'sd8388607) return 24'sh7fffff;
        if (v < -27'sd8388608) return 24'sh800000;
        return v[PW-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/pars_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pars_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/particle_attract_repel_step_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | payload
// in_ch   | in  | pos_x pos_y vel_x vel_y drag sound_level
// out_ch  | out | new_pos_x new_pos_y new_vel_x new_vel_y repelled
// apb     | in  | six registers at 4*i
// One item per cycle while the output is not stalled; the result passes the front
// register, back stages 0..2 (magnitudes, squares, sum), the 25-stage root, the
// 28-stage divider and the output register.
// Reset is synchronous, active low.
// The front register decouples input; back stalls hold the whole pipe.
module particle_attract_repel_step_top import pars_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    pars_if.sink                in_ch,
    pars_if.source              out_ch,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [RAW-1:0] paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    logic signed [23:0] r_cx, r_cy;
    logic [14:0] r_w, r_h;
    logic [15:0] r_th, r_g;
    t_cls w_c;
    logic w_cv, w_cr;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= 24'sd131072;
            r_cy <= 24'sd98304;
            r_w  <= 15'd1024;
            r_h  <= 15'd768;
            r_th <= 16'd52429;
            r_g  <= 16'd39322;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                A_CENTER_X: r_cx <= pwdata[23:0];
                A_CENTER_Y: r_cy <= pwdata[23:0];
                A_WIDTH:    r_w  <= pwdata[14:0];
                A_HEIGHT:   r_h  <= pwdata[14:0];
                A_THRESH:   r_th <= pwdata[15:0];
                A_GAIN:     r_g  <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr)
            A_CENTER_X: prdata = 32'(r_cx);
            A_CENTER_Y: prdata = 32'(r_cy);
            A_WIDTH:    prdata = 32'(r_w);
            A_HEIGHT:   prdata = 32'(r_h);
            A_THRESH:   prdata = 32'(r_th);
            A_GAIN:     prdata = 32'(r_g);
            default:    prdata = '0;
        endcase
    end

    pars_front u_front (
        .i_clk, .i_rst_n,
        .i_center_x(r_cx), .i_center_y(r_cy), .i_width(r_w), .i_height(r_h),
        .i_thresh(r_th),
        .i_in(in_ch.data), .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_cls(w_c), .o_cls_valid(w_cv), .i_cls_ready(w_cr)
    );
    pars_back u_back (
        .i_clk, .i_rst_n, .i_gain(r_g),
        .i_cls(w_c), .i_valid(w_cv), .o_ready(w_cr),
        .o_out(out_ch.data), .o_valid(out_ch.valid), .i_ready(out_ch.ready)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/pars_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pars_front import pars_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic signed [23:0] i_center_x,
    input  wire logic signed [23:0] i_center_y,
    input  wire logic [14:0]       i_width,
    input  wire logic [14:0]       i_height,
    input  wire logic [15:0]       i_thresh,
    input  wire t_in               i_in,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output t_cls                   o_cls,
    output logic                   o_cls_valid,
    input  wire logic              i_cls_ready
);
    logic r_v;
    t_cls r_c, n_c;
    logic signed [25:0] w_px, w_py;

    assign o_in_ready  = !r_v || i_cls_ready;
    assign o_cls_valid = r_v;
    assign o_cls       = r_c;

    always_comb begin
        n_c.rep = i_in.sound_level > i_thresh;
        w_px = 26'(i_in.pos_x);
        w_py = 26'(i_in.pos_y);
        if (n_c.rep) begin
            priority if (w_px > $signed({1'b0, i_width, 8'd0})) begin
                w_px = $signed({1'b0, i_width, 8'd0}) - 26'(EDGE_MARGIN * 256);
            end else if (w_py > $signed({1'b0, i_height, 8'd0})) begin
                w_py = $signed({1'b0, i_height, 8'd0}) - 26'(EDGE_MARGIN * 256);
            end else if (w_px < 0) begin
                w_px = 26'(EDGE_MARGIN * 256);
            end else if (w_py < 0) begin
                w_py = 26'(EDGE_MARGIN * 256);
            end else begin
                // inside the window: keep position
            end
        end
        // snapped values fit in 24 bits (width >= 51 or small negative)
        n_c.px   = w_px[23:0];
        n_c.py   = w_py[23:0];
        n_c.vx   = i_in.vel_x;
        n_c.vy   = i_in.vel_y;
        n_c.drag = i_in.drag;
        n_c.dx   = DW'(i_center_x) - DW'(n_c.px);
        n_c.dy   = DW'(i_center_y) - DW'(n_c.py);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_in_ready) begin
            r_v <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_c <= n_c;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/pars_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined: square per axis, sum, 25-step root, 28-step division per axis, then output.
module pars_back import pars_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_gain,
    input  wire t_cls        i_cls,
    input  wire logic        i_valid,
    output logic             o_ready,
    output t_out             o_out,
    output logic             o_valid,
    input  wire logic        i_ready
);
    localparam int unsigned RS = LW;         // root stages
    localparam int unsigned DS = QW;         // divide stages
    localparam int unsigned NS = 3 + RS + DS + 1;

    typedef struct packed {
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [PW-1:0] vx;
        logic signed [PW-1:0] vy;
        logic                 sx;
        logic                 sy;
        logic                 rep;
    } t_side;

    logic            adv;
    logic [NS-1:0]   r_v;
    t_side           r_sd [NS-1];
    // stage 0..2: magnitudes, drag products, squares, sum
    logic [DW-2:0]   r_mx, r_my;
    logic [39:0]     r_pvx0, r_pvy0;
    logic [DW-2:0]   r_mx1, r_my1;
    logic [47:0]     r_sqx, r_sqy;
    logic [23:0]     r_dvx [1:NS-2];
    logic [23:0]     r_dvy [1:NS-2];
    // root pipeline
    logic [SQW-1:0]  r_rn   [RS+1];
    logic [LW-1:0]   r_rq   [RS+1];
    logic [DW-2:0]   r_rmx  [RS+1];
    logic [DW-2:0]   r_rmy  [RS+1];
    // divide pipeline: numerator, remainders, quotients
    logic [NW-1:0]   w_nx0, w_ny0;
    logic [LW+7:0]   w_den0;
    logic            w_z0;
    logic [NW-1:0]   r_nx [1:DS];
    logic [NW-1:0]   r_ny [1:DS];
    logic [33:0]     r_rx [1:DS];
    logic [33:0]     r_ry [1:DS];
    logic [QW-1:0]   r_qx [1:DS];
    logic [QW-1:0]   r_qy [1:DS];
    logic [LW+7:0]   r_den [1:DS];
    logic            r_z [1:DS];
    t_out            r_o;

    assign adv     = !r_v[NS-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v[NS-1];
    assign o_out   = r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // stage 0: magnitudes, drag product
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sd[0].px  <= i_cls.px;
            r_sd[0].py  <= i_cls.py;
            r_sd[0].vx  <= i_cls.vx;
            r_sd[0].vy  <= i_cls.vy;
            r_sd[0].sx  <= i_cls.dx[DW-1];
            r_sd[0].sy  <= i_cls.dy[DW-1];
            r_sd[0].rep <= i_cls.rep;
            r_mx <= i_cls.dx[DW-1] ? 24'(-i_cls.dx) : i_cls.dx[DW-2:0];
            r_my <= i_cls.dy[DW-1] ? 24'(-i_cls.dy) : i_cls.dy[DW-2:0];
            r_pvx0 <= (i_cls.vx[PW-1] ? 40'(-i_cls.vx) : 40'(i_cls.vx)) * 40'(i_cls.drag);
            r_pvy0 <= (i_cls.vy[PW-1] ? 40'(-i_cls.vy) : 40'(i_cls.vy)) * 40'(i_cls.drag);
            // stage 1: squares, drag rounding
            r_sd[1] <= r_sd[0];
            r_mx1 <= r_mx;
            r_my1 <= r_my;
            r_sqx <= 48'(r_mx) * 48'(r_mx);
            r_sqy <= 48'(r_my) * 48'(r_my);
            r_dvx[1] <= 24'((r_pvx0 + 40'd32768) >> 16);
            r_dvy[1] <= 24'((r_pvy0 + 40'd32768) >> 16);
            // stage 2: sum of squares feeds the root
            r_sd[2] <= r_sd[1];
            r_rn[0]  <= SQW'(r_sqx) + SQW'(r_sqy);
            r_rq[0]  <= '0;
            r_rmx[0] <= r_mx1;
            r_rmy[0] <= r_my1;
            r_dvx[2] <= r_dvx[1];
            r_dvy[2] <= r_dvy[1];
        end
    end

    // restoring root: one result bit per stage, MSB first
    for (genvar k = 0; k < RS; k++) begin : g_root
        logic [SQW-1:0] w_t;
        logic [LW-1:0]  w_q;
        always_comb begin
            w_q = r_rq[k] | (LW'(1) << (RS - 1 - k));
            w_t = SQW'(w_q) * SQW'(w_q);
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rn[k+1]  <= r_rn[k];
                r_rq[k+1]  <= (w_t <= r_rn[k]) ? w_q : r_rq[k];
                r_rmx[k+1] <= r_rmx[k];
                r_rmy[k+1] <= r_rmy[k];
                r_sd[3+k]  <= r_sd[2+k];
                r_dvx[3+k] <= r_dvx[2+k];
                r_dvy[3+k] <= r_dvy[2+k];
            end
        end
    end

    always_comb begin
        w_den0 = {r_rq[RS], 8'd0};
        w_z0   = r_rq[RS] == '0;
        w_nx0  = NW'(i_gain) * NW'(r_rmx[RS]) + NW'({r_rq[RS], 7'd0});
        w_ny0  = NW'(i_gain) * NW'(r_rmy[RS]) + NW'({r_rq[RS], 7'd0});
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < DS; k++) begin : g_div
        logic [NW-1:0] w_nx, w_ny;
        logic [33:0]   w_rx, w_ry, w_ax, w_ay;
        logic [QW-1:0] w_qx, w_qy;
        logic [LW+7:0] w_den;
        logic          w_z;
        if (k == 0) begin : g_seed
            // dividend bits above the quotient width seed the remainder
            assign w_nx  = w_nx0;
            assign w_ny  = w_ny0;
            assign w_rx  = 34'(w_nx0[NW-1:QW]);
            assign w_ry  = 34'(w_ny0[NW-1:QW]);
            assign w_qx  = '0;
            assign w_qy  = '0;
            assign w_den = w_den0;
            assign w_z   = w_z0;
        end else begin : g_chain
            assign w_nx  = r_nx[k];
            assign w_ny  = r_ny[k];
            assign w_rx  = r_rx[k];
            assign w_ry  = r_ry[k];
            assign w_qx  = r_qx[k];
            assign w_qy  = r_qy[k];
            assign w_den = r_den[k];
            assign w_z   = r_z[k];
        end
        always_comb begin
            w_ax = {w_rx[32:0], w_nx[QW-1-k]};
            w_ay = {w_ry[32:0], w_ny[QW-1-k]};
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_nx[k+1]  <= w_nx;
                r_ny[k+1]  <= w_ny;
                r_den[k+1] <= w_den;
                r_z[k+1]   <= w_z;
                r_rx[k+1] <= (w_ax >= 34'(w_den)) ? w_ax - 34'(w_den) : w_ax;
                r_ry[k+1] <= (w_ay >= 34'(w_den)) ? w_ay - 34'(w_den) : w_ay;
                r_qx[k+1] <= {w_qx[QW-2:0], w_ax >= 34'(w_den)};
                r_qy[k+1] <= {w_qy[QW-2:0], w_ay >= 34'(w_den)};
                r_sd[3+RS+k]  <= r_sd[2+RS+k];
                r_dvx[3+RS+k] <= r_dvx[2+RS+k];
                r_dvy[3+RS+k] <= r_dvy[2+RS+k];
            end
        end
    end

    // final: sign, drag, force, position
    logic signed [PW+2:0] w_vx, w_vy, w_fx, w_fy, w_nvx, w_nvy;
    logic signed [PW-1:0] w_svx, w_svy;
    t_side w_s;
    always_comb begin
        w_s  = r_sd[NS-2];
        w_vx = w_s.vx[PW-1] ? -27'(r_dvx[NS-2]) : 27'(r_dvx[NS-2]);
        w_vy = w_s.vy[PW-1] ? -27'(r_dvy[NS-2]) : 27'(r_dvy[NS-2]);
        w_fx = r_z[DS] ? '0 : (w_s.sx ? -27'(r_qx[DS][25:0]) : 27'(r_qx[DS][25:0]));
        w_fy = r_z[DS] ? '0 : (w_s.sy ? -27'(r_qy[DS][25:0]) : 27'(r_qy[DS][25:0]));
        w_nvx = w_s.rep ? w_vx - w_fx : w_vx + w_fx;
        w_nvy = w_s.rep ? w_vy - w_fy : w_vy + w_fy;
        w_svx = sat24(w_nvx);
        w_svy = sat24(w_nvy);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o.new_vel_x <= w_svx;
            r_o.new_vel_y <= w_svy;
            r_o.new_pos_x <= sat24(27'(w_s.px) + 27'(w_svx));
            r_o.new_pos_y <= sat24(27'(w_s.py) + 27'(w_svy));
            r_o.repelled  <= w_s.rep;
        end
    end

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("output item dropped while stalled");
    a_valid_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_v[0]) |=> r_v[1])
        else $error("pipeline lost item");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_o))
        else $error("output changed while stalled");
endmodule
`default_nettype wire

// ===== dv/tb_particle_attract_repel_step_top.sv =====
`timescale 1ns / 1ps
module tb_particle_attract_repel_step_top;
    import pars_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [RAW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    pars_if #(.T(t_in))  in_ch ();
    pars_if #(.T(t_out)) out_ch ();

    particle_attract_repel_step_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the registers
    logic signed [23:0] cx = 24'sd131072, cy = 24'sd98304;
    logic [14:0] win_w = 15'd1024, win_h = 15'd768;
    logic [15:0] thresh = 16'd52429, gain = 16'd39322;

    t_out expected_q[$];
    int errors = 0;
    int send_idle = 0;   // percent
    int recv_stall = 0;  // percent
    bit hold_off = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    function automatic longint mag64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint sat(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint pull(longint d, longint ln);
        longint m;
        if (ln == 0) return 0;
        m = (longint'(gain) * mag64(d) + 128 * ln) / (256 * ln);
        return d < 0 ? -m : m;
    endfunction

    function automatic longint damp(longint v, longint dg);
        longint m;
        m = (mag64(v) * dg + 32768) >>> 16;
        return v < 0 ? -m : m;
    endfunction

    function automatic t_out step_particle(t_in it);
        t_out o;
        longint px, py, vx, vy, dx, dy, ln, fx, fy, nvx, nvy, ww, wh;
        bit rep;
        px = it.pos_x; py = it.pos_y; vx = it.vel_x; vy = it.vel_y;
        ww = win_w; wh = win_h;
        rep = it.sound_level > thresh;
        if (rep) begin
            if (px > ww * 256) px = (ww - EDGE_MARGIN) * 256;
            else if (py > wh * 256) py = (wh - EDGE_MARGIN) * 256;
            else if (px < 0) px = EDGE_MARGIN * 256;
            else if (py < 0) py = EDGE_MARGIN * 256;
        end
        dx = longint'(cx) - px;
        dy = longint'(cy) - py;
        ln = int_sqrt(dx * dx + dy * dy);
        fx = pull(dx, ln);
        fy = pull(dy, ln);
        nvx = damp(vx, it.drag);
        nvy = damp(vy, it.drag);
        if (rep) begin
            nvx -= fx; nvy -= fy;
        end else begin
            nvx += fx; nvy += fy;
        end
        nvx = sat(nvx); nvy = sat(nvy);
        o.new_pos_x = 24'(sat(px + nvx));
        o.new_pos_y = 24'(sat(py + nvy));
        o.new_vel_x = 24'(nvx);
        o.new_vel_y = 24'(nvy);
        o.repelled = rep;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    // checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected item", '0, '0);
            end else begin
                want = expected_q.pop_front();
                if (out_ch.data.new_pos_x !== want.new_pos_x)
                    report_mismatch("new_pos_x", out_ch.data.new_pos_x, want.new_pos_x);
                if (out_ch.data.new_pos_y !== want.new_pos_y)
                    report_mismatch("new_pos_y", out_ch.data.new_pos_y, want.new_pos_y);
                if (out_ch.data.new_vel_x !== want.new_vel_x)
                    report_mismatch("new_vel_x", out_ch.data.new_vel_x, want.new_vel_x);
                if (out_ch.data.new_vel_y !== want.new_vel_y)
                    report_mismatch("new_vel_y", out_ch.data.new_vel_y, want.new_vel_y);
                if (out_ch.data.repelled !== want.repelled)
                    report_mismatch("repelled", 24'(out_ch.data.repelled),
                                    24'(want.repelled));
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (hold_off) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_item(t_in it);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_q.insert(expected_q.size(), step_particle(it));
    endtask

    task automatic end_burst();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [RAW-1:0] addr, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        case (addr)
            A_CENTER_X: cx = val[23:0];
            A_CENTER_Y: cy = val[23:0];
            A_WIDTH:    win_w = val[14:0];
            A_HEIGHT:   win_h = val[14:0];
            A_THRESH:   thresh = val[15:0];
            A_GAIN:     gain = val[15:0];
            default: ;
        endcase
    endtask

    function automatic t_in make_item(int px, int py, int vx, int vy, int dg, int lv);
        t_in it;
        it.pos_x = 24'(px); it.pos_y = 24'(py);
        it.vel_x = 24'(vx); it.vel_y = 24'(vy);
        it.drag = 16'(dg); it.sound_level = 16'(lv);
        return it;
    endfunction

    // mostly positions near the window, sometimes anything
    function automatic t_in rand_item();
        t_in it;
        it.pos_x = ($urandom_range(3) == 0) ? 24'($urandom)
                 : 24'($urandom_range(win_w * 256 + 20000) - 10000);
        it.pos_y = ($urandom_range(3) == 0) ? 24'($urandom)
                 : 24'($urandom_range(win_h * 256 + 20000) - 10000);
        it.vel_x = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(8000) - 4000);
        it.vel_y = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(8000) - 4000);
        it.drag = 16'($urandom);
        it.sound_level = ($urandom_range(1) == 0) ? thresh : 16'($urandom);
        return it;
    endfunction

    task automatic test_directed();
        send_item(make_item(131072, 98304, 1000, -1000, 65535, 0));      // at center
        send_item(make_item(131072, 98304, 0, 0, 0, 65535));             // at center, repel
        send_item(make_item(300000, 1000, 500, 500, 32768, 65535));      // x beyond width
        send_item(make_item(1000, 250000, 500, 500, 32768, 65535));      // y beyond height
        send_item(make_item(-5000, 1000, -500, 0, 40000, 65535));        // x below zero
        send_item(make_item(1000, -5000, 0, -500, 40000, 65535));        // y below zero
        send_item(make_item(8388607, 8388607, 8388607, 8388607, 65535, 0));
        send_item(make_item(-8388608, -8388608, -8388608, -8388608, 65535, 0));
        send_item(make_item(-8388608, -8388608, -8388608, -8388608, 65535, 65535));
        send_item(make_item(8388607, -8388608, 8388607, -8388608, 1, 52429));  // level equal
        send_item(make_item(1000, 2000, 3, -3, 32768, 52430));
        send_item(make_item(0, 0, 1, -1, 32768, 0));
        end_burst();
        drain();
    endtask

    task automatic test_random(int n);
        repeat (n) send_item(rand_item());
        end_burst();
    endtask

    task automatic test_back_pressure();
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            test_random(150);
        join
        drain();
    endtask

    task automatic test_config_sweep();
        write_reg(A_CENTER_X, 32'h7fffff); write_reg(A_CENTER_Y, 32'h800000);
        write_reg(A_WIDTH, 32'd51); write_reg(A_HEIGHT, 32'd32767);
        write_reg(A_THRESH, 32'd0); write_reg(A_GAIN, 32'hffff);
        test_random(60); drain();
        write_reg(A_CENTER_X, 32'h800000); write_reg(A_CENTER_Y, 32'h7fffff);
        write_reg(A_WIDTH, 32'd32767); write_reg(A_HEIGHT, 32'd51);
        write_reg(A_THRESH, 32'hffff); write_reg(A_GAIN, 32'd0);
        test_random(60); drain();
        // narrow window: snap lands below zero
        write_reg(A_WIDTH, 32'd20); write_reg(A_HEIGHT, 32'd10);
        write_reg(A_THRESH, 32'd100); write_reg(A_GAIN, 32'd1234);
        write_reg(A_CENTER_X, 32'd0); write_reg(A_CENTER_Y, 32'd0);
        send_item(make_item(10000, 10000, 0, 0, 65535, 65535));
        send_item(make_item(1000, 5000, 0, 0, 65535, 65535));
        test_random(40); drain();
        write_reg(A_CENTER_X, 32'd131072); write_reg(A_CENTER_Y, 32'd98304);
        write_reg(A_WIDTH, 32'd1024); write_reg(A_HEIGHT, 32'd768);
        write_reg(A_THRESH, 32'd52429); write_reg(A_GAIN, 32'd39322);
    endtask

    task automatic test_idle_phases();
        send_idle = 0;  recv_stall = 0;  test_random(60); drain();
        send_idle = 82; recv_stall = 0;  test_random(50); drain();
        send_idle = 0;  recv_stall = 82; test_random(50); drain();
        send_idle = 6;  recv_stall = 6;  test_random(60); drain();
        send_idle = 0;  recv_stall = 0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_back_pressure();
        test_config_sweep();
        test_idle_phases();
        drain();
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/pars_pkg.sv
hw/rtl/pars_if.sv
hw/rtl/pars_front.sv
hw/rtl/pars_back.sv
hw/rtl/particle_attract_repel_step_top.sv
dv/tb_particle_attract_repel_step_top.sv
